### design/mkt_pkg.sv
`default_nettype none
package mkt_pkg;

    localparam int TABLE_BITS     = 10;
    localparam int TABLE_SIZE     = 1 << TABLE_BITS;
    localparam int GEN_BITS       = 24 - TABLE_BITS;
    localparam int SEGS_PER_BLOCK = 256;
    localparam int SEG_SHIFT      = $clog2(SEGS_PER_BLOCK);

    localparam logic [1:0] FN_ALLOC  = 2'd0;
    localparam logic [1:0] FN_FREE   = 2'd1;
    localparam logic [1:0] FN_LOCAL  = 2'd2;
    localparam logic [1:0] FN_REMOTE = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] key;
        logic [15:0] domain;
        logic        user_domain;
        logic        dma_req;
        logic [63:0] address;
        logic [63:0] io_address;
        logic [63:0] length;
        logic [7:0]  access;
        logic [5:0]  pg_shift;
        logic [63:0] region_offset;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] key_out;
        logic [21:0] segment_major;
        logic [7:0]  segment_minor;
        logic [63:0] segment_offset;
    } t_out;

    typedef struct packed {
        logic [31:0] key;
        logic [15:0] domain;
        logic [63:0] usr_base;
        logic [63:0] io_base;
        logic [63:0] length;
        logic [7:0]  access;
        logic [5:0]  pg_shift;
        logic [63:0] offset;
    } t_slot;

    typedef struct packed {
        logic load;
        logic clr_wr;
        logic scan_rd;
        logic scan_next;
        logic alloc_wr;
        logic dma_set;
        logic lk_rd;
        logic ck1;
        logic free_do;
        logic ck2;
        logic ck3;
        logic res_alloc;
        logic res_full;
        logic res_dma;
        logic res_free;
        logic res_ck;
    } t_cmd;

    typedef struct packed {
        logic       clr_last;
        logic       slot_busy;
        logic       scan_wrap;
        logic       out_free;
        logic [1:0] in_func;
        logic       in_dma;
        logic [1:0] req_func;
    } t_stat;

endpackage
`default_nettype wire

### design/mkt_ram.sv
`default_nettype none
module mkt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

### design/mkt_datapath.sv
`default_nettype none
module mkt_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire mkt_pkg::t_cmd i_cmd,
    output mkt_pkg::t_stat     o_stat,
    input  wire mkt_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output mkt_pkg::t_out      o_out_data
);

    localparam int TB = mkt_pkg::TABLE_BITS;

    mkt_pkg::t_in   r_req;
    logic [TB-1:0]  r_ptr, r_start, r_next, r_clr;
    logic [mkt_pkg::GEN_BITS-1:0] r_gen;
    logic           r_dma;
    logic           r_o_valid;
    mkt_pkg::t_out  r_out;

    logic           v_rdata;
    mkt_pkg::t_slot s_rdata;
    mkt_pkg::t_slot s_wdata;
    logic [TB-1:0]  lk_idx;
    logic           v_we, v_wdata, v_re;
    logic [TB-1:0]  v_waddr, v_raddr;

    logic           r_hit;
    logic [64:0]    r_off;
    logic [63:0]    r_slen, r_soff;
    logic [7:0]     r_sacc;
    logic [5:0]     r_ps;
    logic [64:0]    r_sum;
    logic [63:0]    r_off2;
    logic           r_acc_ok;
    logic           r_rej;
    logic [63:0]    r_shft, r_pgoff;

    logic [mkt_pkg::GEN_BITS-1:0] gen_n;
    logic [31:0]    new_key;
    logic           key_zero;
    logic           local_ck;
    logic [7:0]     acc_and;

    assign lk_idx   = r_req.key[31 -: TB];
    assign key_zero = (r_req.key == 32'd0);
    assign local_ck = (r_req.func == mkt_pkg::FN_LOCAL);
    assign gen_n    = r_gen + 1'b1;
    assign new_key  = {r_ptr, gen_n, 8'h00};
    assign acc_and  = r_sacc & r_req.access;

    always_comb begin
        v_we    = 1'b0;
        v_waddr = r_clr;
        v_wdata = 1'b0;
        if (i_cmd.clr_wr) begin
            v_we = 1'b1;
        end else if (i_cmd.alloc_wr) begin
            v_we    = 1'b1;
            v_waddr = r_ptr;
            v_wdata = 1'b1;
        end else if (i_cmd.free_do && !key_zero && v_rdata && s_rdata.key == r_req.key) begin
            v_we    = 1'b1;
            v_waddr = lk_idx;
        end
        v_re    = i_cmd.scan_rd | i_cmd.lk_rd;
        v_raddr = i_cmd.scan_rd ? r_ptr : lk_idx;
    end

    always_comb begin
        s_wdata            = '0;
        s_wdata.key        = (new_key == 32'd0) ? 32'h0000_0100 : new_key;
        s_wdata.domain     = r_req.domain;
        s_wdata.usr_base   = r_req.address;
        s_wdata.io_base    = r_req.io_address;
        s_wdata.length     = r_req.length;
        s_wdata.access     = r_req.access;
        s_wdata.pg_shift   = r_req.pg_shift;
        s_wdata.offset     = r_req.region_offset;
    end

    mkt_ram #(.WIDTH(1), .DEPTH(mkt_pkg::TABLE_SIZE)) u_valid (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (v_waddr),
        .i_wdata (v_wdata),
        .i_re    (v_re),
        .i_raddr (v_raddr),
        .o_rdata (v_rdata)
    );

    mkt_ram #(.WIDTH($bits(mkt_pkg::t_slot)), .DEPTH(mkt_pkg::TABLE_SIZE)) u_slot (
        .i_clk   (i_clk),
        .i_we    (i_cmd.alloc_wr),
        .i_waddr (r_ptr),
        .i_wdata (s_wdata),
        .i_re    (i_cmd.lk_rd),
        .i_raddr (lk_idx),
        .o_rdata (s_rdata)
    );

    always_comb begin
        o_stat.clr_last  = &r_clr;
        o_stat.slot_busy = v_rdata;
        o_stat.scan_wrap = (TB'(r_ptr + 1'b1) == r_start);
        o_stat.out_free  = !r_o_valid || i_out_ready;
        o_stat.in_func   = i_in_data.func;
        o_stat.in_dma    = i_in_data.dma_req;
        o_stat.req_func  = r_req.func;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= '0;
            r_next    <= '0;
            r_gen     <= '0;
            r_dma     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.alloc_wr) begin
                r_next <= r_ptr + 1'b1;
                r_gen  <= (new_key == 32'd0) ? gen_n + 1'b1 : gen_n;
            end
            if (i_cmd.dma_set) begin
                r_dma <= 1'b1;
            end else if (i_cmd.free_do && key_zero) begin
                r_dma <= 1'b0;
            end
            if (i_cmd.res_alloc || i_cmd.res_full || i_cmd.res_dma ||
                i_cmd.res_free || i_cmd.res_ck) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req   <= i_in_data;
            r_ptr   <= r_next;
            r_start <= r_next;
        end
        if (i_cmd.scan_next) begin
            r_ptr <= r_ptr + 1'b1;
        end
        if (i_cmd.ck1) begin
            r_hit  <= v_rdata && s_rdata.key == r_req.key && s_rdata.domain == r_req.domain;
            r_off  <= {1'b0, r_req.address}
                      - {1'b0, (local_ck ? s_rdata.usr_base : s_rdata.io_base)};
            r_slen <= s_rdata.length;
            r_soff <= s_rdata.offset;
            r_sacc <= s_rdata.access;
            r_ps   <= s_rdata.pg_shift;
        end
        if (i_cmd.ck2) begin
            r_sum    <= {1'b0, r_off[63:0]} + {1'b0, r_req.length};
            r_off2   <= r_off[63:0] + r_soff;
            r_acc_ok <= local_ck ? (acc_and == r_req.access) : (acc_and != 8'd0);
        end
        if (i_cmd.ck3) begin
            if (key_zero) begin
                r_rej <= r_req.user_domain || !r_dma;
            end else begin
                r_rej <= !r_hit || r_off[64] || (r_sum > {1'b0, r_slen}) || !r_acc_ok;
            end
            r_shft  <= r_off2 >> r_ps;
            r_pgoff <= r_off2 & ~({64{1'b1}} << r_ps);
        end
        if (i_cmd.res_alloc) begin
            r_out         <= '0;
            r_out.status  <= mkt_pkg::ST_OK;
            r_out.key_out <= s_wdata.key;
        end else if (i_cmd.res_full) begin
            r_out        <= '0;
            r_out.status <= mkt_pkg::ST_FULL;
        end else if (i_cmd.res_dma) begin
            r_out        <= '0;
            r_out.status <= mkt_pkg::ST_OK;
        end else if (i_cmd.res_free) begin
            r_out         <= '0;
            r_out.status  <= mkt_pkg::ST_OK;
            r_out.key_out <= r_req.key;
        end else if (i_cmd.res_ck) begin
            r_out         <= '0;
            r_out.key_out <= r_req.key;
            if (r_rej) begin
                r_out.status <= mkt_pkg::ST_REJECT;
            end else if (key_zero) begin
                r_out.status         <= mkt_pkg::ST_OK;
                r_out.segment_offset <= r_req.address;
            end else if (r_ps == 6'd0) begin
                r_out.status         <= mkt_pkg::ST_OK;
                r_out.segment_offset <= r_off2;
            end else begin
                r_out.status         <= mkt_pkg::ST_OK;
                r_out.segment_major  <= 22'(r_shft >> mkt_pkg::SEG_SHIFT);
                r_out.segment_minor  <= 8'(r_shft & 64'(mkt_pkg::SEGS_PER_BLOCK - 1));
                r_out.segment_offset <= r_pgoff;
            end
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

### design/mkt_ctrl.sv
`default_nettype none
module mkt_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire mkt_pkg::t_stat i_stat,
    output mkt_pkg::t_cmd       o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_ALLOC, S_FULL, S_DMA,
        S_LK_RD, S_C1, S_FREE, S_C2, S_C3, S_FIN
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        o_cmd      = '0;
        o_in_ready = (r_state == S_IDLE);
        n_state    = r_state;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.in_func == mkt_pkg::FN_ALLOC) begin
                        n_state = i_stat.in_dma ? S_DMA : S_SCAN_RD;
                    end else begin
                        n_state = S_LK_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state       = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (!i_stat.slot_busy) begin
                    n_state = S_ALLOC;
                end else if (i_stat.scan_wrap) begin
                    n_state = S_FULL;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state         = S_SCAN_RD;
                end
            end
            S_ALLOC: begin
                if (i_stat.out_free) begin
                    o_cmd.alloc_wr  = 1'b1;
                    o_cmd.res_alloc = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_FULL: begin
                if (i_stat.out_free) begin
                    o_cmd.res_full = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_DMA: begin
                if (i_stat.out_free) begin
                    o_cmd.dma_set = 1'b1;
                    o_cmd.res_dma = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_LK_RD: begin
                o_cmd.lk_rd = 1'b1;
                n_state     = S_C1;
            end
            S_C1: begin
                o_cmd.ck1 = 1'b1;
                if (i_stat.req_func == mkt_pkg::FN_FREE) begin
                    o_cmd.free_do = 1'b1;
                    n_state       = S_FREE;
                end else begin
                    n_state = S_C2;
                end
            end
            S_FREE: begin
                if (i_stat.out_free) begin
                    o_cmd.res_free = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_C2: begin
                o_cmd.ck2 = 1'b1;
                n_state   = S_C3;
            end
            S_C3: begin
                o_cmd.ck3 = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.res_ck = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

### design/memory_key_table_top.sv
// Memory-region key table: allocate, free, local check and remote check, one
// result beat per input beat. After reset the slot valid memory is cleared one
// entry per cycle, all 1024 entries, before the first input is taken. A DMA
// allocate sets the DMA flag; an allocate scans the valid memory for a free
// slot from the next pointer, up to 1024 slots; a free clears a slot after a lookup
// read; a check does the lookup read and then the three-stage bounds, offset and
// page-split pipeline. A new input is taken only once the last result is in the
// output register, where a finished result waits.
`default_nettype none
module memory_key_table_top (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire mkt_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output mkt_pkg::t_out      o_out_data
);

    mkt_pkg::t_cmd  cmd;
    mkt_pkg::t_stat stat;

    mkt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mkt_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

### tb/memory_key_table_checker.sv
`timescale 1ns / 1ps
module memory_key_table_checker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_ready,
    input  wire mkt_pkg::t_in  i_in_data,
    input  wire logic          i_out_valid,
    input  wire logic          i_out_ready,
    input  wire mkt_pkg::t_out i_out_data,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_results
);
    import mkt_pkg::*;

    localparam int IDX_SHIFT = 32 - TABLE_BITS;

    logic                    valid_q [TABLE_SIZE];
    t_slot                   region_q [TABLE_SIZE];
    logic [TABLE_BITS-1:0]   next_ptr;
    logic [GEN_BITS-1:0]     gen_cnt;
    logic                    dma_on;
    t_out                    expected_q [$];

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, exp, $time);
        o_errors++;
    endtask

    function automatic t_out predict_beat(input t_in b);
        t_out                  r;
        logic [TABLE_BITS-1:0] idx;
        logic [31:0]           k;
        logic [63:0]           base, off, pg;
        logic [64:0]           sum;
        logic                  ok;
        int                    n;
        r = '0;
        r.key_out = b.key;
        case (b.func)
            FN_ALLOC: begin
                r.key_out = '0;
                if (b.dma_req) begin
                    dma_on = 1'b1;
                end else begin
                    idx = next_ptr;
                    n = 0;
                    while (valid_q[idx] && n < TABLE_SIZE) begin
                        idx++;
                        n++;
                    end
                    if (n == TABLE_SIZE) begin
                        r.status = ST_FULL;
                    end else begin
                        next_ptr = idx + 1'b1;
                        gen_cnt++;
                        k = {idx, gen_cnt, 8'h00};
                        if (k == 0) begin
                            k[8] = 1'b1;
                            gen_cnt++;
                        end
                        valid_q[idx] = 1'b1;
                        region_q[idx] = '{key: k, domain: b.domain, usr_base: b.address,
                            io_base: b.io_address, length: b.length, access: b.access,
                            pg_shift: b.pg_shift, offset: b.region_offset};
                        r.key_out = k;
                    end
                end
            end
            FN_FREE: begin
                idx = b.key[31:IDX_SHIFT];
                if (b.key == 0) dma_on = 1'b0;
                else if (valid_q[idx] && region_q[idx].key == b.key) valid_q[idx] = 1'b0;
            end
            default: begin
                idx = b.key[31:IDX_SHIFT];
                if (b.key == 0) begin
                    if (b.user_domain || !dma_on) r.status = ST_REJECT;
                    else r.segment_offset = b.address;
                end else begin
                    ok = valid_q[idx] && region_q[idx].key == b.key
                        && region_q[idx].domain == b.domain;
                    if (ok) begin
                        base = (b.func == FN_REMOTE) ? region_q[idx].io_base
                                                     : region_q[idx].usr_base;
                        off = b.address - base;
                        sum = {1'b0, off} + {1'b0, b.length};
                        if (b.address < base || sum > {1'b0, region_q[idx].length}) ok = 0;
                        if (b.func == FN_REMOTE) begin
                            if ((region_q[idx].access & b.access) == 0) ok = 0;
                        end else if ((region_q[idx].access & b.access) != b.access) begin
                            ok = 0;
                        end
                    end
                    if (!ok) begin
                        r.status = ST_REJECT;
                    end else begin
                        off = off + region_q[idx].offset;
                        if (region_q[idx].pg_shift == 0) begin
                            r.segment_offset = off;
                        end else begin
                            pg = off >> region_q[idx].pg_shift;
                            r.segment_major = pg[SEG_SHIFT +: 22];
                            r.segment_minor = pg[7:0];
                            r.segment_offset = off & ((64'd1 << region_q[idx].pg_shift) - 1);
                        end
                    end
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out e;
        if (!i_rst_n) begin
            foreach (valid_q[j]) valid_q[j] = 1'b0;
            next_ptr = '0;
            gen_cnt = '0;
            dma_on = 1'b0;
            expected_q.delete();
            o_errors = 0;
            o_results = 0;
        end else begin
            if (i_in_valid && i_in_ready) expected_q.push_back(predict_beat(i_in_data));
            if (i_out_valid && i_out_ready) begin
                o_results++;
                if (expected_q.size() == 0) begin
                    report("unexpected beat", i_out_data.key_out, 0);
                end else begin
                    e = expected_q.pop_front();
                    if (i_out_data.status != e.status)
                        report("status", i_out_data.status, e.status);
                    if (i_out_data.key_out != e.key_out)
                        report("key_out", i_out_data.key_out, e.key_out);
                    if (i_out_data.segment_major != e.segment_major)
                        report("segment_major", i_out_data.segment_major, e.segment_major);
                    if (i_out_data.segment_minor != e.segment_minor)
                        report("segment_minor", i_out_data.segment_minor, e.segment_minor);
                    if (i_out_data.segment_offset != e.segment_offset)
                        report("segment_offset", i_out_data.segment_offset, e.segment_offset);
                end
            end
        end
        o_pending = expected_q.size();
    end
endmodule

### tb/memory_key_table_top_tb.sv
`timescale 1ns / 1ps
module memory_key_table_top_tb;
    import mkt_pkg::*;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_in_valid = 0;
    logic o_in_ready;
    t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 0;
    t_out o_out_data;
    int   errors, pending, results;
    bit   hold_off = 0;
    int   n_alloc, n_free, n_check;
    t_in  regions [$];
    logic [31:0] keys_of [$];
    logic [31:0] last_key;

    memory_key_table_top dut (.*);

    memory_key_table_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .i_in_ready(o_in_ready),
        .i_in_data(i_in_data), .i_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_out_data(o_out_data), .o_errors(errors), .o_pending(pending),
        .o_results(results)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("Some tests failed");
        $finish;
    end

    // receiver stall pattern, with a long hold-off each time one is requested
    initial begin
        int mode;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                i_out_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_off = 0;
            end
            mode = int'(($time / 20000) % 3);
            if (mode == 0) i_out_ready <= 1'b1;
            else if (mode == 1) i_out_ready <= ($urandom_range(0, 3) != 0);
            else i_out_ready <= ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge i_clk)
        if (o_out_valid && i_out_ready) last_key <= o_out_data.key_out;

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] edge64();
        case ($urandom_range(0, 4))
            0: return 64'd0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000;
            default: return rnd64();
        endcase
    endfunction

    function automatic logic [63:0] lo_val();
        return 64'($urandom_range(0, 4096));
    endfunction

    // valid stays up after the accepting edge; the next send or a pause takes it
    task automatic send(input t_in b);
        i_in_valid <= 1'b1;
        i_in_data <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        case (b.func)
            FN_ALLOC: n_alloc++;
            FN_FREE:  n_free++;
            default:  n_check++;
        endcase
    endtask

    task automatic pause(input int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain();
        pause(1);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic rand_beat(input bit well_formed);
        t_in b;
        int  j;
        b.func = 2'($urandom_range(0, 3));
        b.key = $urandom();
        b.domain = 16'($urandom());
        b.user_domain = 1'($urandom());
        b.dma_req = ($urandom_range(0, 9) == 0);
        b.address = edge64();
        b.io_address = edge64();
        b.length = edge64();
        b.access = 8'($urandom());
        b.pg_shift = 6'($urandom());
        b.region_offset = edge64();
        if (well_formed && b.func == FN_ALLOC) begin
            b.address = rnd64() & 64'hFFFF_FFFF_FFFF_0000;
            b.io_address = rnd64() & 64'hFFFF_FFFF_FFFF_0000;
            b.length = 64'($urandom_range(1, 1 << 20));
        end
        if (well_formed && b.func != FN_ALLOC && regions.size() != 0) begin
            j = $urandom_range(0, regions.size() - 1);
            b.key = keys_of[j];
            if ($urandom_range(0, 4) != 0) b.domain = regions[j].domain;
            if (b.func == FN_FREE) begin
                if ($urandom_range(0, 2) != 0) return;
                regions.delete(j);
                keys_of.delete(j);
            end else begin
                b.address = (b.func == FN_REMOTE ? regions[j].io_address : regions[j].address)
                          + 64'($urandom_range(0, 1 << 20)) - 64'd16;
                b.length = 64'($urandom_range(0, 1 << 12));
                b.access = $urandom_range(0, 1) ? regions[j].access : 8'($urandom());
            end
        end else if (b.func == FN_FREE && $urandom_range(0, 3) == 0) begin
            b.key = 0;
        end
        send(b);
        if (b.func == FN_ALLOC && !b.dma_req) begin
            drain();
        end
    endtask

    task automatic add_region(input t_in b);
        send(b);
        drain();
        @(posedge i_clk);
        if (last_key != 0) begin
            regions.push_back(b);
            keys_of.push_back(last_key);
        end
    endtask

    initial begin
        t_in b;
        int  burst;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        b = '0;
        b.func = FN_LOCAL;
        send(b);
        b.func = FN_ALLOC; b.dma_req = 1; send(b); send(b);
        b.dma_req = 0;
        b.func = FN_REMOTE; b.address = '1; b.user_domain = 0; send(b);
        b.user_domain = 1; send(b);
        b.func = FN_FREE; b.key = 0; send(b);
        b.func = FN_LOCAL; b.user_domain = 0; send(b);
        b = '0;
        b.func = FN_ALLOC; b.domain = 16'hFFFF; b.address = 64'h1000; b.io_address = '1;
        b.length = '1; b.access = 8'hFF; b.pg_shift = 6'd63; b.region_offset = '1;
        add_region(b);
        b.address = 64'h0; b.io_address = 64'h100; b.length = 64'h1000; b.access = 8'h05;
        b.pg_shift = 6'd12; b.region_offset = 64'h123; b.domain = 0;
        add_region(b);
        b.pg_shift = 0; add_region(b);
        for (int i = 0; i < keys_of.size(); i++) begin
            t_in c;
            c = regions[i];
            c.key = keys_of[i];
            c.func = FN_LOCAL; c.length = 64'h10; send(c);
            c.address = c.address - 64'd1; send(c);
            c.address = '1; c.length = '1; send(c);
            c.func = FN_REMOTE; c.address = regions[i].io_address; c.access = 8'h02; send(c);
            c.access = 8'h04; send(c);
            c.domain = ~c.domain; send(c);
        end
        b.func = FN_FREE; b.key = keys_of[0] ^ 32'h100; send(b);
        b.key = keys_of[0]; send(b);
        b.func = FN_LOCAL; b.domain = regions[0].domain; send(b);
        regions.delete(0); keys_of.delete(0);
        drain();

        // random part
        for (int n = 0; n < 750; ) begin
            burst = $urandom_range(1, 20);
            if (n > 200 && n < 230) hold_off = 1;
            for (int k = 0; k < burst; k++, n++) begin
                if ($urandom_range(0, 4) == 0) begin
                    b.func = FN_ALLOC;
                    b.dma_req = 0;
                    b.domain = 16'($urandom());
                    b.user_domain = 1'($urandom());
                    b.key = $urandom();
                    b.address = rnd64() & 64'hFFFF_FFFF_FFFF_0000;
                    b.io_address = edge64();
                    b.length = 64'($urandom_range(1, 1 << 20));
                    b.access = 8'($urandom());
                    b.pg_shift = 6'($urandom());
                    b.region_offset = edge64();
                    add_region(b);
                end else begin
                    rand_beat($urandom_range(0, 4) != 0);
                end
            end
            if ($urandom_range(0, 9) == 0) drain();
            else pause($urandom_range(1, 12));
        end

        drain();
        repeat (50) @(posedge i_clk);
        $display("Covered %0d allocates, %0d frees, %0d checks; %0d result beats compared",
                 n_alloc, n_free, n_check, results);
        if (errors == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

### files.f
design/mkt_pkg.sv
design/mkt_ram.sv
design/mkt_datapath.sv
design/mkt_ctrl.sv
design/memory_key_table_top.sv
tb/memory_key_table_checker.sv
tb/memory_key_table_top_tb.sv
